@@ rtl/core/bmf_pkg.sv @@
// Shared widths, register codes and types of the box mean filter.
package bmf_pkg;

    localparam int K_W        = 4;
    localparam int W_W        = 12;
    localparam int H_W        = 16;
    localparam int PIX_W      = 8;
    localparam int MEAN_W     = 8;
    localparam int P_W        = 3;
    localparam int SIDE_W     = P_W + 1;
    localparam int ROW_W      = H_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    localparam logic [K_W-1:0] KERNEL_RESET = 4'd3;
    localparam logic [W_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [H_W-1:0] HEIGHT_RESET = 16'd480;

    localparam logic [MEAN_W-1:0] MEAN_MAX = 8'd255;

    // Effective window geometry after clamping of the kernel register.
    typedef struct packed {
        logic [K_W-1:0]    k;
        logic [P_W-1:0]    p;
        logic [SIDE_W-1:0] side;
    } t_geom;

    // One classified stream position handed from the front to the back.
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             old_ok;
        logic             fresh;
        logic             emit;
        logic             row_end;
        logic             last_row;
    } t_cmd;

endpackage

@@ rtl/core/bmf_if.sv @@
// Channel interfaces of the box mean filter: pixel input, configuration, results.
interface bmf_pix_if import bmf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             action;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, output action, output pixel_value, input ready);
    modport sink   (input valid, input action, input pixel_value, output ready);
endinterface

interface bmf_cfg_if import bmf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface bmf_res_if import bmf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MEAN_W-1:0] mean_value;
    logic              last_of_frame;

    modport source (output valid, output mean_value, output last_of_frame, input ready);
    modport sink   (input valid, input mean_value, input last_of_frame, output ready);
endinterface

@@ rtl/core/bmf_queue.sv @@
// Short command queue between the front and the back of the box mean filter.
module bmf_queue
    import bmf_pkg::*;
#(
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);

    logic [DATA_W-1:0]  r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, n_wp;
    logic [Q_PTR_W-1:0] r_rp, n_rp;
    logic [Q_PTR_W:0]   r_cnt, n_cnt;

    always_comb begin
        n_wp  = i_push ? r_wp + Q_PTR_W'(1) : r_wp;
        n_rp  = i_pop ? r_rp + Q_PTR_W'(1) : r_rp;
        n_cnt = r_cnt + (Q_PTR_W+1)'(i_push) - (Q_PTR_W+1)'(i_pop);
    end

    assign o_full  = r_cnt == (Q_PTR_W+1)'(Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/core/bmf_front.sv @@
// Front of the box mean filter: registers, stream position and item classification.
module bmf_front
    import bmf_pkg::*;
#(
    parameter int MAX_KERNEL = 15,
    parameter int MAX_WIDTH  = 2048,
    localparam int SIDE_MAX = 2 * (MAX_KERNEL / 2) + 1,
    localparam int COL_W    = $clog2(MAX_WIDTH),
    localparam int SLOT_W   = (SIDE_MAX > 1) ? $clog2(SIDE_MAX) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bmf_pix_if.sink           i_pix,
    bmf_cfg_if.sink           i_cfg,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_cmd              o_cmd,
    output logic [COL_W-1:0]  o_col,
    output logic [SLOT_W-1:0] o_slot,
    output t_geom             o_geom
);

    logic [K_W-1:0]    r_kernel;
    logic [W_W-1:0]    r_width;
    logic [H_W-1:0]    r_height;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [SLOT_W-1:0] r_slot, n_slot;

    logic [K_W-1:0]    k_eff;
    logic [W_W-1:0]    w_eff;
    logic [H_W-1:0]    h_eff;
    logic [P_W-1:0]    pad;
    logic [SIDE_W-1:0] side;
    logic [COL_W-1:0]  col_last;
    logic [ROW_W-1:0]  h_ext;
    logic              is_real, in_frame, skip, accept;
    logic              emit_row, row_end, last_row, done;
    logic              cfg_wr, cfg_known;

    always_comb begin
        k_eff = r_kernel;
        if (r_kernel == '0) begin
            k_eff = K_W'(1);
        end else if (int'(r_kernel) > MAX_KERNEL) begin
            k_eff = K_W'(MAX_KERNEL);
        end
        w_eff = r_width;
        if (r_width == '0) begin
            w_eff = W_W'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_eff = W_W'(MAX_WIDTH);
        end
        h_eff    = (r_height == '0) ? H_W'(1) : r_height;
        pad      = P_W'(k_eff >> 1);
        side     = {pad, 1'b1};
        col_last = COL_W'(w_eff - W_W'(1));
        h_ext    = ROW_W'(h_eff);
    end

    assign o_geom = '{k: k_eff, p: pad, side: side};

    always_comb begin
        is_real  = i_pix.action == ACT_PIXEL;
        in_frame = r_row < h_ext;
        // A drain tick while the frame still runs is taken and thrown away.
        skip     = !is_real && in_frame;
        accept   = i_pix.valid && i_pix.ready;
        o_q_push = accept && !skip;
        emit_row = (r_row >= ROW_W'(pad)) && (r_row < h_ext + ROW_W'(pad));
        row_end  = r_col == col_last;
        last_row = r_row == h_ext + ROW_W'(pad) - ROW_W'(1);
        done     = emit_row && row_end && last_row;

        o_cmd.pix      = (is_real && in_frame) ? i_pix.pixel_value : '0;
        o_cmd.old_ok   = r_row >= ROW_W'(side);
        o_cmd.fresh    = r_row == '0;
        o_cmd.emit     = emit_row;
        o_cmd.row_end  = row_end;
        o_cmd.last_row = last_row;
    end

    assign o_col       = r_col;
    assign o_slot      = r_slot;
    assign i_pix.ready = !i_q_full;
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign cfg_known   = (i_cfg.index == REG_KERNEL) || (i_cfg.index == REG_WIDTH)
                         || (i_cfg.index == REG_HEIGHT);

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_slot = r_slot;
        if (cfg_wr && cfg_known) begin
            n_col  = '0;
            n_row  = '0;
            n_slot = '0;
        end else if (o_q_push) begin
            if (done) begin
                n_col  = '0;
                n_row  = '0;
                n_slot = '0;
            end else if (row_end) begin
                n_col  = '0;
                n_row  = r_row + ROW_W'(1);
                n_slot = (r_slot == SLOT_W'(side - SIDE_W'(1))) ? '0 : r_slot + SLOT_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= KERNEL_RESET;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_slot   <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_slot <= n_slot;
            if (cfg_wr) begin
                unique case (i_cfg.index)
                    REG_KERNEL: r_kernel <= i_cfg.data[K_W-1:0];
                    REG_WIDTH:  r_width  <= i_cfg.data[W_W-1:0];
                    REG_HEIGHT: r_height <= i_cfg.data[H_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

@@ rtl/core/bmf_back.sv @@
// Back of the box mean filter: line store, column sums and the running window sum.
module bmf_back
    import bmf_pkg::*;
#(
    parameter int MAX_KERNEL = 15,
    parameter int MAX_WIDTH  = 2048,
    localparam int SIDE_MAX = 2 * (MAX_KERNEL / 2) + 1,
    localparam int COL_W    = $clog2(MAX_WIDTH),
    localparam int SLOT_W   = (SIDE_MAX > 1) ? $clog2(SIDE_MAX) : 1,
    localparam int CS_W     = $clog2(SIDE_MAX * 255 + 1),
    localparam int SUM_W    = $clog2(SIDE_MAX * SIDE_MAX * 255 + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_geom             i_geom,
    input  logic              i_empty,
    input  t_cmd              i_cmd,
    input  logic [COL_W-1:0]  i_col,
    input  logic [SLOT_W-1:0] i_slot,
    output logic              o_pop,
    output logic              o_emit_valid,
    output logic [SUM_W-1:0]  o_sum,
    output logic              o_last,
    input  logic              i_emit_ready
);

    localparam int LS_DEPTH = SIDE_MAX << COL_W;
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_TAIL = 2'd2;

    logic [PIX_W-1:0] r_ls [LS_DEPTH];
    logic [CS_W-1:0]  r_cs [MAX_WIDTH];
    logic [CS_W-1:0]  r_tap [SIDE_MAX];

    logic [1:0]        r_state, n_state;
    t_cmd              r_cmd;
    logic [COL_W-1:0]  r_col;
    logic [SLOT_W-1:0] r_slot;
    logic [PIX_W-1:0]  r_ls_q;
    logic [CS_W-1:0]   r_cs_q;
    logic [SUM_W-1:0]  r_hsum, n_hsum;
    logic [P_W-1:0]    r_step, n_step;

    logic [CS_W-1:0]   tap_old, cs_new, tap_in, sub;
    logic [COL_W:0]    vcol;
    logic [SUM_W-1:0]  hs_base;
    logic              emit_need, go, shift;

    assign o_pop   = (r_state == ST_IDLE) && !i_empty;
    assign tap_old = r_tap[SLOT_W'(i_geom.side - SIDE_W'(1))];

    always_comb begin
        // Vertical sum of the window rows at this column: add the new row, drop the
        // row that leaves the window unless it lies above the frame.
        cs_new = (r_cmd.fresh ? CS_W'(0) : r_cs_q) + CS_W'(r_cmd.pix)
                 - (r_cmd.old_ok ? CS_W'(r_ls_q) : CS_W'(0));
        vcol    = {1'b0, r_col} + (COL_W+1)'(r_state == ST_TAIL ? r_step : P_W'(0));
        sub     = (int'(vcol) >= int'(i_geom.side)) ? tap_old : CS_W'(0);
        hs_base = (r_state == ST_UPD && r_col == '0) ? SUM_W'(0) : r_hsum;
        tap_in  = (r_state == ST_UPD) ? cs_new : CS_W'(0);
        n_hsum  = hs_base + SUM_W'(tap_in) - SUM_W'(sub);
        emit_need = 1'b0;
        o_last    = 1'b0;
        if (r_state == ST_UPD) begin
            emit_need = r_cmd.emit && (int'(r_col) >= int'(i_geom.p));
            o_last    = r_cmd.last_row && r_cmd.row_end && (i_geom.p == '0);
        end else if (r_state == ST_TAIL) begin
            emit_need = int'(vcol) >= int'(i_geom.p);
            o_last    = r_cmd.last_row && (r_step == i_geom.p);
        end
        o_emit_valid = emit_need;
        o_sum        = n_hsum;
        go           = !emit_need || i_emit_ready;
        shift        = ((r_state == ST_UPD) || (r_state == ST_TAIL)) && go;
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (go) begin
                    if (r_cmd.emit && r_cmd.row_end && (i_geom.p != '0)) begin
                        n_state = ST_TAIL;
                        n_step  = P_W'(1);
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_TAIL: begin
                if (go) begin
                    if (r_step == i_geom.p) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_step = r_step + P_W'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        if (o_pop) begin
            r_cmd  <= i_cmd;
            r_col  <= i_col;
            r_slot <= i_slot;
        end
        if (shift) begin
            r_hsum   <= n_hsum;
            r_tap[0] <= tap_in;
            for (int i = 1; i < SIDE_MAX; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ls_q <= r_ls[{i_slot, i_col}];
        end
        if (r_state == ST_UPD && go) begin
            r_ls[{r_slot, r_col}] <= r_cmd.pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cs_q <= r_cs[i_col];
        end
        if (r_state == ST_UPD && go) begin
            r_cs[r_col] <= cs_new;
        end
    end

endmodule

@@ rtl/core/bmf_scale.sv @@
// Division of the window sum by K*K through a reciprocal multiply, with saturation.
module bmf_scale
    import bmf_pkg::*;
#(
    parameter int MAX_KERNEL = 15,
    localparam int SIDE_MAX = 2 * (MAX_KERNEL / 2) + 1,
    localparam int SUM_W    = $clog2(SIDE_MAX * SIDE_MAX * 255 + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_geom            i_geom,
    input  logic             i_valid,
    input  logic [SUM_W-1:0] i_sum,
    input  logic             i_last,
    output logic             o_ready,
    bmf_res_if.source        o_res
);

    localparam int D_W    = 2 * K_W;
    localparam int SHIFT  = SUM_W + D_W;
    localparam int M_W    = SHIFT + 1;
    localparam int PROD_W = SUM_W + M_W;
    localparam int N_K    = 1 << K_W;

    logic [M_W-1:0]    w_rcp [N_K];
    logic [PROD_W-1:0] r_prod;
    logic              r_v1, r_l1;
    logic              r_v2;
    logic [SUM_W:0]    quot;
    logic              adv2;

    // Rounded-up reciprocals 2^SHIFT / K^2; exact floor for every sum the window can reach.
    for (genvar g = 0; g < N_K; g++) begin : g_rcp
        localparam longint unsigned DIV = (g == 0) ? 1 : g * g;
        localparam longint unsigned RCP = ((64'd1 << SHIFT) + DIV - 1) / DIV;
        assign w_rcp[g] = M_W'(RCP);
    end

    assign adv2    = !r_v2 || o_res.ready;
    assign o_ready = !r_v1 || adv2;
    assign quot    = r_prod[PROD_W-1:SHIFT];
    assign o_res.valid = r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod <= PROD_W'(i_sum) * PROD_W'(w_rcp[i_geom.k]);
            r_l1   <= i_last;
        end
        if (adv2 && r_v1) begin
            o_res.mean_value    <= (quot > (SUM_W+1)'(MEAN_MAX)) ? MEAN_MAX : quot[MEAN_W-1:0];
            o_res.last_of_frame <= r_l1;
        end
    end

endmodule

@@ rtl/core/box_mean_filter_2d.sv @@
// Top level of the streaming zero-padded 2-D box mean filter.
//
//   Channel  Direction  Carries
//   i_pix    in         action (pixel or drain tick), pixel_value
//   i_cfg    in         index (0 kernel_size, 1 image_width, 2 image_height), data
//   o_res    out        mean_value, last_of_frame
//
// For each accepted pixel the back reads the line store and the column-sum memory,
// then writes them and updates the running window sum. At the end of an output row
// a tail state yields the p = floor(K/2) extra results, one per step. A queue of up
// to four transactions between the front and the back keeps input flowing while the
// back or the output stalls, until it is full. Reset is synchronous, active low and
// restores K=3, W=640, H=480; a configuration write to a known index restarts the frame.
module box_mean_filter_2d
    import bmf_pkg::*;
#(
    parameter int MAX_KERNEL = 15,
    parameter int MAX_WIDTH  = 2048
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bmf_pix_if.sink   i_pix,
    bmf_cfg_if.sink   i_cfg,
    bmf_res_if.source o_res
);

    localparam int SIDE_MAX = 2 * (MAX_KERNEL / 2) + 1;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int SLOT_W   = (SIDE_MAX > 1) ? $clog2(SIDE_MAX) : 1;
    localparam int SUM_W    = $clog2(SIDE_MAX * SIDE_MAX * 255 + 1);
    localparam int CMD_W    = $bits(t_cmd);
    localparam int Q_W      = SLOT_W + COL_W + CMD_W;

    t_geom             w_geom;
    logic              w_q_push, w_q_pop, w_q_full, w_q_empty;
    t_cmd              w_f_cmd, w_b_cmd;
    logic [COL_W-1:0]  w_f_col, w_b_col;
    logic [SLOT_W-1:0] w_f_slot, w_b_slot;
    logic [Q_W-1:0]    w_q_head;
    logic              w_emit_valid, w_emit_ready, w_emit_last;
    logic [SUM_W-1:0]  w_emit_sum;

    // The front classifies each transaction and tracks the stream position.
    bmf_front #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (i_pix),
        .i_cfg    (i_cfg),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_cmd    (w_f_cmd),
        .o_col    (w_f_col),
        .o_slot   (w_f_slot),
        .o_geom   (w_geom)
    );

    bmf_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  ({w_f_slot, w_f_col, w_f_cmd}),
        .i_pop   (w_q_pop),
        .o_data  (w_q_head),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    assign {w_b_slot, w_b_col, w_b_cmd} = w_q_head;

    // The back keeps the rows of the window and forms one window sum per result.
    bmf_back #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_geom       (w_geom),
        .i_empty      (w_q_empty),
        .i_cmd        (w_b_cmd),
        .i_col        (w_b_col),
        .i_slot       (w_b_slot),
        .o_pop        (w_q_pop),
        .o_emit_valid (w_emit_valid),
        .o_sum        (w_emit_sum),
        .o_last       (w_emit_last),
        .i_emit_ready (w_emit_ready)
    );

    // Two registered stages turn the sum into the saturated mean on the output.
    bmf_scale #(
        .MAX_KERNEL (MAX_KERNEL)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (w_geom),
        .i_valid (w_emit_valid),
        .i_sum   (w_emit_sum),
        .i_last  (w_emit_last),
        .o_ready (w_emit_ready),
        .o_res   (o_res)
    );

`ifndef ASSERT_OFF
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full)
        else $error("command queue written while full");

    a_queue_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("command queue read while empty");

    a_emit_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit_valid && !w_emit_ready)
        |=> (w_emit_valid && $stable(w_emit_sum) && $stable(w_emit_last)))
        else $error("window sum changed while the scaler stalled");
`endif

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the streaming 2-D box mean filter.
module tb;
    import bmf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Mirror of the line store: one slot of MAX_WIDTH pixels per window row.
    localparam int MAXK      = 15;
    localparam int MAXW      = 2048;
    localparam int SIDE_MAX  = 2 * (MAXK / 2) + 1;
    localparam int LIMIT     = 2_000_000;
    localparam int SETTLE    = 80;

    typedef struct {
        logic [MEAN_W-1:0] mean;
        logic              last;
    } t_mean_res;

    logic i_clk;
    logic i_rst_n;

    bmf_pix_if pix_ch ();
    bmf_cfg_if cfg_ch ();
    bmf_res_if res_ch ();

    box_mean_filter_2d u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // Predicted filter state, kept apart from the design.
    logic [PIX_W-1:0] line_mirror [SIDE_MAX*MAXW];
    int               col_pos;
    int               row_pos;
    logic [K_W-1:0]   kernel_reg;
    logic [W_W-1:0]   width_reg;
    logic [H_W-1:0]   height_reg;

    t_mean_res        pending_means [$];
    int               error_count;
    int               cycle_count;
    bit               idle_off;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // A stalled run ends here rather than hanging the simulator.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic int eff_kernel();
        return (kernel_reg == 0) ? 1 : int'(kernel_reg);
    endfunction

    function automatic int eff_width();
        if (width_reg == 0) return 1;
        if (int'(width_reg) > MAXW) return MAXW;
        return int'(width_reg);
    endfunction

    function automatic int eff_height();
        return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    // Mean over the zero-padded window centered on (r, c), saturated.
    function automatic logic [MEAN_W-1:0] box_mean(int r, int c, int k, int w, int h);
        int p;
        int side;
        int sum;
        int mean;
        p    = k / 2;
        side = 2 * p + 1;
        sum  = 0;
        for (int rr = r - p; rr <= r + p; rr++) begin
            if (rr < 0 || rr >= h) continue;
            for (int cc = c - p; cc <= c + p; cc++) begin
                if (cc < 0 || cc >= w) continue;
                sum += int'(line_mirror[(rr % side) * MAXW + cc]);
            end
        end
        mean = sum / (k * k);
        return (mean > 255) ? MEAN_MAX : MEAN_W'(mean);
    endfunction

    // Advances the mirrored state by one accepted transaction and queues the
    // means it releases. A row end releases up to the last p+1 columns at once.
    task automatic predict_means(logic act, logic [PIX_W-1:0] pix);
        int k, w, h, p, side, r, c_lo, c_hi;
        bit real_px, done;
        t_mean_res res;
        k       = eff_kernel();
        w       = eff_width();
        h       = eff_height();
        p       = k / 2;
        side    = 2 * p + 1;
        real_px = (act == ACT_PIXEL);
        done    = 0;
        if (col_pos >= w) col_pos = 0;
        // A drain tick that arrives while the frame is still coming is dropped.
        if (!real_px && row_pos < h) return;
        line_mirror[(row_pos % side) * MAXW + col_pos] =
            (real_px && row_pos < h) ? pix : '0;
        if (row_pos >= p && row_pos - p < h) begin
            r = row_pos - p;
            if (col_pos + 1 < w) begin
                c_lo = col_pos - p;
                c_hi = col_pos - p;
            end else begin
                c_lo = (w - 1 >= p) ? (w - 1 - p) : 0;
                c_hi = w - 1;
            end
            for (int c = c_lo; c <= c_hi && c >= 0; c++) begin
                res.mean = box_mean(r, c, k, w, h);
                res.last = (r == h - 1) && (c == w - 1);
                pending_means.push_back(res);
                if (res.last) done = 1;
            end
        end
        if (done) begin
            col_pos = 0;
            row_pos = 0;
        end else if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    // Mostly back-to-back, sometimes a short pause, rarely a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (idle_off) return 0;
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Sends one pixel-channel transaction and updates the prediction when
    // it is taken. Valid stays high between back-to-back transactions.
    task automatic send_pixel(logic act, logic [PIX_W-1:0] pix);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.action      <= act;
        pix_ch.pixel_value <= pix;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        predict_means(act, pix);
    endtask

    // Registers change only with the block idle: every mean delivered and
    // enough cycles for transactions that release nothing to pass through.
    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_KERNEL: kernel_reg = data[K_W-1:0];
            REG_WIDTH:  width_reg  = data[W_W-1:0];
            REG_HEIGHT: height_reg = data[H_W-1:0];
            default:    return;
        endcase
        // Any write to a real register restarts the frame.
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic set_geometry(int k, int w, int h);
        write_reg(REG_KERNEL, CFG_DATA_W'(k));
        write_reg(REG_WIDTH,  CFG_DATA_W'(w));
        write_reg(REG_HEIGHT, CFG_DATA_W'(h));
    endtask

    // One whole frame plus its drain ticks. With noise, a share of the
    // transactions get a random action, which exercises dropped drain ticks
    // and pixels that arrive while the bottom rows are flushing.
    task automatic send_frame(int noise_pct, output int sent);
        int total;
        logic act;
        total = eff_height() * eff_width() + (eff_kernel() / 2) * eff_width();
        sent  = 0;
        for (int i = 0; i < total; i++) begin
            act = (i < eff_height() * eff_width()) ? ACT_PIXEL : ACT_DRAIN;
            if ($urandom_range(99) < noise_pct) act = $urandom_range(1);
            send_pixel(act, $urandom_range(255));
            sent++;
        end
    endtask

    // Result side: random back-pressure and an in-order check of every mean.
    int stall_left;
    always @(posedge i_clk) begin
        t_mean_res want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else begin
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end else begin
                res_ch.ready <= 1'b1;
                stall_left   <= pick_gap();
            end
            if (res_ch.valid && res_ch.ready) begin
                if (pending_means.size() == 0) begin
                    $display("%0t: unexpected result mean=%0d last=%0b", $time,
                             res_ch.mean_value, res_ch.last_of_frame);
                    error_count++;
                end else begin
                    want = pending_means.pop_front();
                    if (res_ch.mean_value !== want.mean) begin
                        $display("%0t: mean_value expected %0d actual %0d", $time,
                                 want.mean, res_ch.mean_value);
                        error_count++;
                    end
                    if (res_ch.last_of_frame !== want.last) begin
                        $display("%0t: last_of_frame expected %0b actual %0b", $time,
                                 want.last, res_ch.last_of_frame);
                        error_count++;
                    end
                end
            end
        end
    end

    // Reset values: one row of 640 and part of the next at K=3.
    task automatic test_reset_geometry();
        for (int i = 0; i < 660; i++) send_pixel(ACT_PIXEL, $urandom_range(255));
    endtask

    // Small frames covering pixel extremes, early drain ticks, a pixel in
    // the drain, kernel zero, height zero and an even kernel that saturates.
    task automatic test_directed();
        int sent;
        set_geometry(3, 3, 3);
        send_pixel(ACT_DRAIN, 8'hAA);
        for (int i = 0; i < 9; i++) send_pixel(ACT_PIXEL, (i % 2) ? 8'hFF : 8'h00);
        send_pixel(ACT_DRAIN, 8'h55);
        send_pixel(ACT_PIXEL, 8'hFF);
        send_pixel(ACT_DRAIN, 8'h00);
        set_geometry(0, 1, 0);
        send_pixel(ACT_PIXEL, 8'hFF);
        set_geometry(2, 3, 2);
        for (int i = 0; i < 6; i++) send_pixel(ACT_PIXEL, 8'hFF);
        for (int i = 0; i < 3; i++) send_pixel(ACT_DRAIN, 8'hFF);
        set_geometry(14, 2, 1);
        send_frame(0, sent);
    endtask

    // Largest kernel, clamped and exact maximum width, tallest height, and
    // a write to the unused index that must leave the frame running.
    task automatic test_extremes();
        int sent;
        set_geometry(15, 8, 2);
        send_frame(0, sent);
        set_geometry(1, 4095, 1);
        send_frame(0, sent);
        set_geometry(1, 2048, 1);
        send_frame(0, sent);
        set_geometry(1, 5, 65535);
        for (int i = 0; i < 6; i++) send_pixel(ACT_PIXEL, $urandom_range(255));
        write_reg(2'd3, 16'hFFFF);
        for (int i = 0; i < 6; i++) send_pixel(ACT_PIXEL, $urandom_range(255));
        write_reg(REG_WIDTH, 16'h0000);
        for (int i = 0; i < 4; i++) send_pixel(ACT_PIXEL, $urandom_range(255));
    endtask

    // Random frames: mostly clean, some noisy, a few cut short by a restart.
    task automatic test_random_frames();
        int count, sent, k, w, h;
        count = 0;
        while (count < 220) begin
            k = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(5);
            w = $urandom_range(12, 1);
            h = $urandom_range(6, 1);
            idle_off = ($urandom_range(4) == 0);
            set_geometry(k, w, h);
            if ($urandom_range(5) == 0) begin
                sent = $urandom_range(w * h);
                for (int i = 0; i < sent; i++)
                    send_pixel($urandom_range(1), $urandom_range(255));
            end else begin
                send_frame(($urandom_range(3) == 0) ? 15 : 0, sent);
            end
            count += sent;
        end
        idle_off = 0;
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        pix_ch.valid       <= 1'b0;
        pix_ch.action      <= ACT_PIXEL;
        pix_ch.pixel_value <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_KERNEL;
        cfg_ch.data        <= '0;
        error_count         = 0;
        cycle_count         = 0;
        idle_off            = 0;
        col_pos             = 0;
        row_pos             = 0;
        kernel_reg          = KERNEL_RESET;
        width_reg           = WIDTH_RESET;
        height_reg          = HEIGHT_RESET;
        foreach (line_mirror[i]) line_mirror[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_geometry();
        test_directed();
        test_extremes();
        test_random_frames();

        wait_idle();
        if (error_count == 0 && pending_means.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
